/* src/rtfss_pkg.sv */
// Shared types and constants for the room temperature filter and source select block.
package rtfss_pkg;

  localparam int TIME_W    = 48;
  localparam int TEMP_W    = 16;
  localparam int HUM_W     = 15;
  localparam int FILT_W    = 24;
  localparam int TGT_SHIFT = FILT_W - TEMP_W;
  localparam int TAU_W     = 22;
  localparam int VAL_W     = 20;
  localparam int CFG_W     = 22;
  localparam int AGE_MS_W  = 32;

  localparam int US_PER_MS = 1000;
  localparam int VUS_W     = 30;  // validity window in microseconds
  localparam int TUS_W     = 32;  // time constant in microseconds
  localparam int DEN_W     = 33;  // tau_us + dt
  localparam int AREM_W    = 34;  // alpha divider remainder, doubled
  localparam int DIFF_W    = 25;  // target - filtered
  localparam int MREM_W    = 10;  // remainder of the divide by 1000

  // age to ms: long division by 1000, one byte of the age per step
  localparam int AGE_DIGIT_W  = 8;
  localparam int AGE_DIGITS   = TIME_W / AGE_DIGIT_W;
  localparam int MDIV_W       = MREM_W + AGE_DIGIT_W;
  localparam int MS_PRE_SHIFT = 3;   // 1000 = 8 * 125
  localparam int MREC_W       = 16;
  localparam int MREC_SHIFT   = 22;
  localparam int MPRD_W       = MDIV_W - MS_PRE_SHIFT + MREC_W;
  localparam logic [MREC_W-1:0] MS_RECIP = 16'd33555;  // ceil(2^22 / 125)

  localparam int CNT_W     = 6;

  localparam logic [VAL_W-1:0] VALIDITY_RESET = 20'd30000;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_EXT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_EXT = 2'd2;

  localparam logic CFG_TAU      = 1'b0;
  localparam logic CFG_VALIDITY = 1'b1;

  typedef struct packed {
    logic load;
    logic age;
    logic prep;
    logic div_step;
    logic alpha_step;
    logic mul;
    logic commit;
    logic eval;
    logic write;
  } cmd_t;

endpackage

/* src/rtfss_ctrl.sv */
// Sequencing state machine for the room temperature filter and source select block.
module rtfss_ctrl import rtfss_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_AGE    = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_EVAL   = 3'd6;
  localparam logic [2:0] S_WRITE  = 3'd7;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_AGE;
        end
      end
      S_AGE: begin
        cmd.age    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        // age steps fit inside the coefficient divide (FRAC_BITS >= 6)
        cmd.alpha_step = 1'b1;
        cmd.div_step   = (cnt < CNT_W'(AGE_DIGITS));
        cnt_next       = cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        // hold until the result register is free
        if (slot_free) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.write) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/rtfss_dp.sv */
// Datapath of the room temperature filter and source select block: state, dividers, filter.
module rtfss_dp import rtfss_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [OP_W-1:0]          opcode,
  input  logic [TIME_W-1:0]        time_us,
  input  logic                     temp_present,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic                     humidity_present,
  input  logic [HUM_W-1:0]         humidity_in,
  output logic signed [TEMP_W-1:0] effective_temp,
  output logic                     effective_valid,
  output logic                     from_external,
  output logic signed [TEMP_W-1:0] filtered_sensor_temp,
  output logic signed [TEMP_W-1:0] raw_sensor_temp,
  output logic                     sensor_valid,
  output logic [AGE_MS_W-1:0]      sensor_age_ms,
  output logic signed [TEMP_W-1:0] external_temp_out,
  output logic                     external_valid,
  output logic [HUM_W-1:0]         humidity_out,
  output logic                     humidity_valid,
  output logic                     valid_changed
);

  localparam int PROD_W = FRAC_BITS + DIFF_W + 1;

  // configuration
  logic [TAU_W-1:0] tau_ms;
  logic [VAL_W-1:0] validity_ms;
  logic [TUS_W-1:0] tau_us;
  logic [VUS_W-1:0] val_us;

  // request
  logic [OP_W-1:0]          req_op;
  logic [TIME_W-1:0]        req_now;
  logic                     req_tp;
  logic signed [TEMP_W-1:0] req_temp;
  logic                     req_hp;
  logic [HUM_W-1:0]         req_hum;

  // architectural state
  logic signed [FILT_W-1:0] filtered;
  logic signed [TEMP_W-1:0] raw_temp;
  logic [TIME_W-1:0]        sensor_time;
  logic                     sensor_seen;
  logic signed [TEMP_W-1:0] ext_value;
  logic [TIME_W-1:0]        ext_time;
  logic                     ext_seen;
  logic                     use_ext;
  logic [HUM_W-1:0]         hum_value;
  logic [TIME_W-1:0]        hum_time;
  logic                     hum_seen;
  logic                     prev_eff_valid;

  // working registers
  logic [TIME_W-1:0]        sens_age;
  logic                     seed;
  logic [DEN_W-1:0]         den;
  logic [AREM_W-1:0]        arem;
  logic [FRAC_BITS-1:0]     alpha;
  logic [TIME_W-1:0]        mq;
  logic [MREM_W-1:0]        mrem;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic                     sen_v;
  logic                     ext_v;
  logic                     hum_v;

  // combinational helpers
  logic signed [FILT_W-1:0] target;
  logic [AREM_W-1:0]        arem_dbl;
  logic                     a_ge;
  logic [MDIV_W-1:0]        m_try;
  logic [MPRD_W-1:0]        m_prd;
  logic [AGE_DIGIT_W-1:0]   m_q;
  logic [MDIV_W-1:0]        m_back;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [FILT_W-1:0] step;
  logic                     eff_v;

  function automatic logic [TIME_W-1:0] age_of(input logic [TIME_W-1:0] stamp,
                                               input logic [TIME_W-1:0] now);
    age_of = (now >= stamp) ? (now - stamp) : '0;
  endfunction

  assign tau_us   = TUS_W'(tau_ms) * TUS_W'(US_PER_MS);
  assign val_us   = VUS_W'(validity_ms) * VUS_W'(US_PER_MS);
  assign target   = {req_temp, {TGT_SHIFT{1'b0}}};
  assign arem_dbl = {arem[AREM_W-2:0], 1'b0};
  assign a_ge     = (arem_dbl >= AREM_W'(den));
  // one quotient byte per step: divide by 8, then by 125 through its
  // reciprocal, exact for every partial dividend below 1000 * 256
  assign m_try    = {mrem, mq[TIME_W-1 -: AGE_DIGIT_W]};
  assign m_prd    = MPRD_W'(m_try[MDIV_W-1:MS_PRE_SHIFT]) * MPRD_W'(MS_RECIP);
  assign m_q      = m_prd[MREC_SHIFT +: AGE_DIGIT_W];
  assign m_back   = MDIV_W'(m_q) * MDIV_W'(US_PER_MS);
  assign prod_shr = prod >>> FRAC_BITS;
  assign step     = prod_shr[FILT_W-1:0];
  assign eff_v    = use_ext ? ext_v : sen_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      tau_ms      <= '0;
      validity_ms <= VALIDITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAU:      tau_ms      <= cfg_data[TAU_W-1:0];
        CFG_VALIDITY: validity_ms <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // state that survives between requests
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered       <= '0;
      raw_temp       <= '0;
      sensor_time    <= '0;
      sensor_seen    <= 1'b0;
      ext_value      <= '0;
      ext_time       <= '0;
      ext_seen       <= 1'b0;
      use_ext        <= 1'b0;
      hum_value      <= '0;
      hum_time       <= '0;
      hum_seen       <= 1'b0;
      prev_eff_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        case (req_op)
          OP_SAMPLE: begin
            if (req_tp) begin
              raw_temp    <= req_temp;
              filtered    <= seed ? target : filtered + step;
              sensor_time <= req_now;
              sensor_seen <= 1'b1;
            end
            if (req_hp) begin
              hum_value <= req_hum;
              hum_time  <= req_now;
              hum_seen  <= 1'b1;
            end
          end
          OP_SET_EXT: begin
            use_ext   <= 1'b1;
            ext_value <= req_temp;
            ext_time  <= req_now;
            ext_seen  <= 1'b1;
          end
          OP_CLR_EXT: begin
            use_ext  <= 1'b0;
            ext_seen <= 1'b0;
            ext_time <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.write && req_op == OP_SAMPLE) begin
        prev_eff_valid <= eff_v;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= opcode;
      req_now  <= time_us;
      req_tp   <= temp_present;
      req_temp <= temperature;
      req_hp   <= humidity_present;
      req_hum  <= humidity_in;
    end
    if (cmd.age) begin
      sens_age <= age_of(sensor_time, req_now);
    end
    if (cmd.prep) begin
      seed  <= (tau_ms == '0) || !(sensor_seen && sens_age <= TIME_W'(val_us));
      // dt stays inside the validity window whenever the filter runs
      den   <= DEN_W'(tau_us) + DEN_W'(sens_age[VUS_W-1:0]);
      arem  <= AREM_W'(sens_age[VUS_W-1:0]);
      alpha <= '0;
      mq    <= (req_op == OP_SAMPLE && req_tp) ? '0 : sens_age;
      mrem  <= '0;
      diff  <= DIFF_W'(target) - DIFF_W'(filtered);
    end
    if (cmd.alpha_step) begin
      arem  <= a_ge ? (arem_dbl - AREM_W'(den)) : arem_dbl;
      alpha <= {alpha[FRAC_BITS-2:0], a_ge};
    end
    if (cmd.div_step) begin
      mrem <= MREM_W'(m_try - m_back);
      mq   <= {mq[TIME_W-AGE_DIGIT_W-1:0], m_q};
    end
    if (cmd.mul) begin
      prod <= PROD_W'($signed({1'b0, alpha})) * PROD_W'(diff);
    end
    if (cmd.eval) begin
      sen_v <= sensor_seen && (age_of(sensor_time, req_now) <= TIME_W'(val_us));
      ext_v <= ext_seen && (age_of(ext_time, req_now) <= TIME_W'(val_us));
      hum_v <= hum_seen && (age_of(hum_time, req_now) <= TIME_W'(val_us));
    end
    if (cmd.write) begin
      effective_valid      <= eff_v;
      from_external        <= use_ext;
      filtered_sensor_temp <= filtered[FILT_W-1:TGT_SHIFT];
      raw_sensor_temp      <= raw_temp;
      sensor_valid         <= sen_v;
      external_temp_out    <= ext_value;
      external_valid       <= ext_v;
      humidity_out         <= hum_value;
      humidity_valid       <= hum_v;
      valid_changed        <= (req_op == OP_SAMPLE) && (eff_v != prev_eff_valid);
      if (!eff_v) begin
        effective_temp <= '0;
      end else if (use_ext) begin
        effective_temp <= ext_value;
      end else begin
        effective_temp <= filtered[FILT_W-1:TGT_SHIFT];
      end
      if (!sensor_seen) begin
        sensor_age_ms <= '0;
      end else if (|mq[TIME_W-1:AGE_MS_W]) begin
        sensor_age_ms <= '1;
      end else begin
        sensor_age_ms <= mq[AGE_MS_W-1:0];
      end
    end
  end

endmodule

/* src/room_temp_filter_source_select.sv */
// Top level of the room temperature filter and source select block.
//
// Requests arrive on the input channel (in_valid / in_stall) with an opcode,
// a microsecond timestamp and optional temperature and humidity readings.
// Every request yields exactly one result on the output channel
// (out_valid / out_stall) carrying the selected temperature, the filtered
// and raw sensor values, ages, validity flags and the validity change flag.
// A request is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// One request is worked on at a time. Each request walks through the age,
// prep, divide, multiply, commit, evaluate and write states, and the next
// request is taken only after the write. The bit-serial coefficient divide
// is the longest of these: FRAC_BITS (16) steps, one per cycle, with the age
// conversion to milliseconds running beside it in six byte-wide steps.
// A result waiting in the output register does not block the next request;
// that request then holds in its last step until the register is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) go straight into the registers.
// Reset clears all stored readings, deselects the external source and loads
// the register defaults (filter off, 30000 ms validity window).
module room_temp_filter_source_select import rtfss_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          opcode,
  input  logic [TIME_W-1:0]        time_us,
  input  logic                     temp_present,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic                     humidity_present,
  input  logic [HUM_W-1:0]         humidity_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] effective_temp,
  output logic                     effective_valid,
  output logic                     from_external,
  output logic signed [TEMP_W-1:0] filtered_sensor_temp,
  output logic signed [TEMP_W-1:0] raw_sensor_temp,
  output logic                     sensor_valid,
  output logic [AGE_MS_W-1:0]      sensor_age_ms,
  output logic signed [TEMP_W-1:0] external_temp_out,
  output logic                     external_valid,
  output logic [HUM_W-1:0]         humidity_out,
  output logic                     humidity_valid,
  output logic                     valid_changed
);

  cmd_t cmd;

  // sequencer: walks each request through age, prep, divide, multiply, commit, eval and write
  rtfss_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // stored readings, dividers, filter and result register
  rtfss_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .opcode               (opcode),
    .time_us              (time_us),
    .temp_present         (temp_present),
    .temperature          (temperature),
    .humidity_present     (humidity_present),
    .humidity_in          (humidity_in),
    .effective_temp       (effective_temp),
    .effective_valid      (effective_valid),
    .from_external        (from_external),
    .filtered_sensor_temp (filtered_sensor_temp),
    .raw_sensor_temp      (raw_sensor_temp),
    .sensor_valid         (sensor_valid),
    .sensor_age_ms        (sensor_age_ms),
    .external_temp_out    (external_temp_out),
    .external_valid       (external_valid),
    .humidity_out         (humidity_out),
    .humidity_valid       (humidity_valid),
    .valid_changed        (valid_changed)
  );

endmodule

/* src/rtfss_chk.sv */
// Port-level checks for the room temperature filter and source select block.
module rtfss_chk import rtfss_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [TEMP_W-1:0] effective_temp,
  input logic                     effective_valid,
  input logic                     from_external,
  input logic                     sensor_valid,
  input logic                     external_valid,
  input logic [AGE_MS_W-1:0]      sensor_age_ms
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(effective_temp) && $stable(sensor_age_ms))
    else $error("result changed while stalled");

  // one request in flight: taking a request closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // effective validity follows the selected source
  a_select: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> effective_valid == (from_external ? external_valid : sensor_valid))
    else $error("effective validity does not match selected source");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !effective_valid |-> effective_temp == '0)
    else $error("invalid effective temperature is not zero");

endmodule

bind room_temp_filter_source_select rtfss_chk u_rtfss_chk (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the room temperature filter and source select block.
module tb_top;
  import rtfss_pkg::*;

  localparam int ALPHA_FRAC     = 16;
  localparam int DRAIN_CYCLES   = 60;    // one full request plus margin
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake or register write
  localparam int TAU_MAX        = 3600000;
  localparam int VALIDITY_MAX   = 600000;
  localparam int PHASE_ITEMS    = 330;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // One result of the block, field by field.
  typedef struct {
    logic signed [TEMP_W-1:0] eff_temp;
    logic                     eff_valid;
    logic                     ext_selected;
    logic signed [TEMP_W-1:0] filt_temp;
    logic signed [TEMP_W-1:0] raw_temp;
    logic                     sens_valid;
    logic [AGE_MS_W-1:0]      sens_age_ms;
    logic signed [TEMP_W-1:0] ext_temp;
    logic                     ext_valid;
    logic [HUM_W-1:0]         hum;
    logic                     hum_valid;
    logic                     validity_flip;
  } room_report_t;

  // Mirror of the conditioner: keeps its own copy of the stored readings and
  // registers, works out the report for each accepted request and queues it.
  class room_conditioner_mirror;
    logic [TAU_W-1:0]         tau_ms;
    logic [VAL_W-1:0]         window_ms;
    logic signed [FILT_W-1:0] filt;
    logic signed [TEMP_W-1:0] raw_value;
    logic [TIME_W-1:0]        sensor_stamp;
    logic                     sensor_seen;
    logic signed [TEMP_W-1:0] ext_value;
    logic [TIME_W-1:0]        ext_stamp;
    logic                     ext_seen;
    logic                     use_ext;
    logic [HUM_W-1:0]         hum_value;
    logic [TIME_W-1:0]        hum_stamp;
    logic                     hum_seen;
    logic                     prev_eff_valid;
    int                       mismatches;
    room_report_t             pending_reports[$];

    function new();
      tau_ms         = '0;
      window_ms      = VALIDITY_RESET;
      filt           = '0;
      raw_value      = '0;
      sensor_stamp   = '0;
      sensor_seen    = 1'b0;
      ext_value      = '0;
      ext_stamp      = '0;
      ext_seen       = 1'b0;
      use_ext        = 1'b0;
      hum_value      = '0;
      hum_stamp      = '0;
      hum_seen       = 1'b0;
      prev_eff_valid = 1'b0;
      mismatches     = 0;
    endfunction

    function void write_register(logic idx, logic [CFG_W-1:0] data);
      if (idx == CFG_TAU) begin
        tau_ms = data[TAU_W-1:0];
      end else begin
        window_ms = data[VAL_W-1:0];
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    // Time running backwards counts as zero age.
    function longint unsigned age_us(logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] now);
      return (now >= stamp) ? longint'(now - stamp) : 0;
    endfunction

    function logic fresh(logic seen, logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] now);
      return seen && (age_us(stamp, now) <= longint'(window_ms) * 1000);
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] now, logic tp,
                               logic signed [TEMP_W-1:0] temp, logic hp,
                               logic [HUM_W-1:0] hum);
      room_report_t    want;
      longint          target, prod, sum;
      longint unsigned dt, alpha, age_ms;
      logic            sens_ok, ext_ok, hum_ok, eff_ok;
      want = '{default: '0};
      case (op)
        OP_SAMPLE: begin
          if (tp) begin
            target    = longint'(temp) * 256;
            raw_value = temp;
            // Reseed when filtering is off or the last reading went stale.
            if (tau_ms == 0 || !fresh(sensor_seen, sensor_stamp, now)) begin
              filt = target[FILT_W-1:0];
            end else begin
              dt    = age_us(sensor_stamp, now);
              alpha = (dt << ALPHA_FRAC) / (longint'(tau_ms) * 1000 + dt);
              prod  = longint'(alpha) * (target - longint'(filt));
              sum   = longint'(filt) + (prod >>> ALPHA_FRAC);
              filt  = sum[FILT_W-1:0];
            end
            sensor_stamp = now;
            sensor_seen  = 1'b1;
          end
          if (hp) begin
            hum_value = hum;
            hum_stamp = now;
            hum_seen  = 1'b1;
          end
        end
        OP_SET_EXT: begin
          use_ext   = 1'b1;
          ext_value = temp;
          ext_stamp = now;
          ext_seen  = 1'b1;
        end
        OP_CLR_EXT: begin
          // Keep the last external value visible, but forget it was set.
          use_ext   = 1'b0;
          ext_seen  = 1'b0;
          ext_stamp = '0;
        end
        default: begin
        end
      endcase

      sens_ok = fresh(sensor_seen, sensor_stamp, now);
      ext_ok  = fresh(ext_seen, ext_stamp, now);
      hum_ok  = fresh(hum_seen, hum_stamp, now);
      if (use_ext) begin
        eff_ok = ext_ok;
        want.eff_temp = ext_ok ? ext_value : '0;
      end else begin
        eff_ok = sens_ok;
        want.eff_temp = sens_ok ? filt[FILT_W-1:TGT_SHIFT] : '0;
      end
      if (op == OP_SAMPLE) begin
        want.validity_flip = (eff_ok != prev_eff_valid);
        prev_eff_valid     = eff_ok;
      end
      age_ms = 0;
      if (sensor_seen) begin
        age_ms = age_us(sensor_stamp, now) / 1000;
        if (age_ms > 64'hFFFF_FFFF) age_ms = 64'hFFFF_FFFF;
      end

      want.eff_valid    = eff_ok;
      want.ext_selected = use_ext;
      want.filt_temp    = filt[FILT_W-1:TGT_SHIFT];
      want.raw_temp     = raw_value;
      want.sens_valid   = sens_ok;
      want.sens_age_ms  = age_ms[AGE_MS_W-1:0];
      want.ext_temp     = ext_value;
      want.ext_valid    = ext_ok;
      want.hum          = hum_value;
      want.hum_valid    = hum_ok;
      pending_reports.push_back(want);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(room_report_t got);
      room_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t ns: result arrived with no request outstanding", $time);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("effective_temp", want.eff_temp, got.eff_temp);
      compare_field("effective_valid", want.eff_valid, got.eff_valid);
      compare_field("from_external", want.ext_selected, got.ext_selected);
      compare_field("filtered_sensor_temp", want.filt_temp, got.filt_temp);
      compare_field("raw_sensor_temp", want.raw_temp, got.raw_temp);
      compare_field("sensor_valid", want.sens_valid, got.sens_valid);
      compare_field("sensor_age_ms", want.sens_age_ms, got.sens_age_ms);
      compare_field("external_temp_out", want.ext_temp, got.ext_temp);
      compare_field("external_valid", want.ext_valid, got.ext_valid);
      compare_field("humidity_out", want.hum, got.hum);
      compare_field("humidity_valid", want.hum_valid, got.hum_valid);
      compare_field("valid_changed", want.validity_flip, got.validity_flip);
    endfunction
  endclass

  // Clock, reset and every block input start at a known value.
  logic                     clk              = 1'b0;
  logic                     rst              = 1'b1;
  logic                     cfg_we           = 1'b0;
  logic                     cfg_index        = CFG_TAU;
  logic [CFG_W-1:0]         cfg_data         = '0;
  logic                     in_valid         = 1'b0;
  logic [OP_W-1:0]          opcode           = OP_SAMPLE;
  logic [TIME_W-1:0]        time_us          = '0;
  logic                     temp_present     = 1'b0;
  logic signed [TEMP_W-1:0] temperature      = '0;
  logic                     humidity_present = 1'b0;
  logic [HUM_W-1:0]         humidity_in      = '0;
  logic                     out_stall        = 1'b0;

  logic                     in_stall;
  logic                     out_valid;
  logic signed [TEMP_W-1:0] effective_temp;
  logic                     effective_valid;
  logic                     from_external;
  logic signed [TEMP_W-1:0] filtered_sensor_temp;
  logic signed [TEMP_W-1:0] raw_sensor_temp;
  logic                     sensor_valid;
  logic [AGE_MS_W-1:0]      sensor_age_ms;
  logic signed [TEMP_W-1:0] external_temp_out;
  logic                     external_valid;
  logic [HUM_W-1:0]         humidity_out;
  logic                     humidity_valid;
  logic                     valid_changed;

  room_conditioner_mirror mirror = new();

  int                sender_gap_pct     = 29;
  int                receiver_stall_pct = 54;
  int                window_ms_now      = VALIDITY_RESET;
  int                quiet_cycles       = 0;
  logic [TIME_W-1:0] stamp_now          = '0;

  room_temp_filter_source_select #(.FRAC_BITS(ALPHA_FRAC)) uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .opcode              (opcode),
    .time_us             (time_us),
    .temp_present        (temp_present),
    .temperature         (temperature),
    .humidity_present    (humidity_present),
    .humidity_in         (humidity_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .effective_temp      (effective_temp),
    .effective_valid     (effective_valid),
    .from_external       (from_external),
    .filtered_sensor_temp(filtered_sensor_temp),
    .raw_sensor_temp     (raw_sensor_temp),
    .sensor_valid        (sensor_valid),
    .sensor_age_ms       (sensor_age_ms),
    .external_temp_out   (external_temp_out),
    .external_valid      (external_valid),
    .humidity_out        (humidity_out),
    .humidity_valid      (humidity_valid),
    .valid_changed       (valid_changed)
  );

  // 2 ns period: rising edges at odd ns, falling edges at even ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random; the rate follows the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Sample every handshake at the rising edge. Register writes go to the
  // mirror first, then the accepted request, then the accepted result, so a
  // result is always checked against expectations queued before it.
  always @(posedge clk) begin
    room_report_t got;
    if (!rst) begin
      if (cfg_we) mirror.write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        mirror.take_request(opcode, time_us, temp_present, temperature,
                            humidity_present, humidity_in);
      end
      if (out_valid && !out_stall) begin
        got.eff_temp      = effective_temp;
        got.eff_valid     = effective_valid;
        got.ext_selected  = from_external;
        got.filt_temp     = filtered_sensor_temp;
        got.raw_temp      = raw_sensor_temp;
        got.sens_valid    = sensor_valid;
        got.sens_age_ms   = sensor_age_ms;
        got.ext_temp      = external_temp_out;
        got.ext_valid     = external_valid;
        got.hum           = humidity_out;
        got.hum_valid     = humidity_valid;
        got.validity_flip = valid_changed;
        mirror.check_report(got);
      end
      // Watchdog: any handshake or register write counts as progress.
      if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: watchdog expired, %0d results still outstanding",
                 $time, mirror.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Present one request and hold it until taken. Entered and left at a
  // falling edge; valid stays high on return so back-to-back requests do not
  // drop it in between.
  task automatic send_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] stamp, logic tp,
                              logic signed [TEMP_W-1:0] temp, logic hp,
                              logic [HUM_W-1:0] hum);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    opcode           <= op;
    time_us          <= stamp;
    temp_present     <= tp;
    temperature      <= temp;
    humidity_present <= hp;
    humidity_in      <= hum;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the block go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both registers on consecutive cycles while the block is idle.
  task automatic apply_settings(int tau, int validity);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TAU;
    cfg_data  <= CFG_W'(tau);
    @(negedge clk);
    cfg_index <= CFG_VALIDITY;
    cfg_data  <= CFG_W'(validity);
    @(negedge clk);
    cfg_we        <= 1'b0;
    window_ms_now  = validity;
  endtask

  // Random request. Time mostly advances by amounts comparable to the
  // validity window so that filter updates, stale reseeds and expiry all
  // happen; now and then it stands still, steps back or jumps anywhere.
  task automatic send_random_request();
    int                       pick;
    longint                   window_us, back;
    logic [OP_W-1:0]          op;
    logic signed [TEMP_W-1:0] temp;
    pick = $urandom_range(0, 99);
    if (pick < 60) op = OP_SAMPLE;
    else if (pick < 72) op = OP_SET_EXT;
    else if (pick < 80) op = OP_CLR_EXT;
    else op = OP_QUERY;

    window_us = longint'(window_ms_now) * 1000;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      stamp_now = {16'($urandom), $urandom};
    end else if (pick < 8) begin
      back = $urandom_range(0, 32'(2 * window_us + 10));
      stamp_now = (stamp_now > TIME_W'(back)) ? stamp_now - TIME_W'(back) : '0;
    end else if (pick < 20) begin
      // hold the time: zero elapsed
    end else if (pick < 30) begin
      stamp_now = stamp_now + TIME_W'($urandom_range(0, 2000));
    end else begin
      stamp_now = stamp_now + TIME_W'($urandom_range(0, 32'(window_us + window_us / 3 + 1000)));
    end

    if ($urandom_range(0, 3) == 0) temp = TEMP_W'($urandom);
    else temp = TEMP_W'(3000 + $urandom_range(0, 4000));

    send_request(op, stamp_now, ($urandom_range(0, 4) != 0), temp,
                 ($urandom_range(0, 9) < 7), HUM_W'($urandom_range(0, 25600)));
  endtask

  initial begin
    int tau, validity;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: filter off, 30 s window.
    send_request(OP_QUERY,   48'd0,          1'b0, 16'sd0,  1'b0, 15'd0);   // nothing seen yet
    send_request(OP_SAMPLE,  48'd1000,       1'b1, 16'sd32767, 1'b1, 15'd25600);
    send_request(OP_SAMPLE,  48'd2000,       1'b1, -16'sd32768, 1'b0, 15'd0);
    send_request(OP_SET_EXT, 48'd3000,       1'b0, -16'sd32768, 1'b0, 15'd0);
    send_request(OP_QUERY,   48'd30_003_000, 1'b0, 16'sd0,  1'b0, 15'd0);   // age equals window
    send_request(OP_QUERY,   48'd30_003_001, 1'b0, 16'sd0,  1'b0, 15'd0);   // one past window
    send_request(OP_CLR_EXT, 48'd30_004_000, 1'b0, 16'sd0,  1'b0, 15'd0);
    send_request(OP_SAMPLE,  48'd30_005_000, 1'b0, 16'sd0,  1'b0, 15'd0);   // validity drops
    send_request(OP_SAMPLE,  48'd10_000,     1'b1, 16'sd0,  1'b1, 15'd0);   // time backwards
    settle();

    // Filter on with a short window.
    apply_settings(1000, 5000);
    send_request(OP_SAMPLE,  48'd20_000_000, 1'b1, 16'sd2560, 1'b0, 15'd0); // stale: reseed
    send_request(OP_SAMPLE,  48'd20_500_000, 1'b1, 16'sd5120, 1'b0, 15'd0); // step upward
    send_request(OP_SAMPLE,  48'd20_750_000, 1'b1, -16'sd5120, 1'b0, 15'd0); // step downward
    send_request(OP_SAMPLE,  48'd26_000_000, 1'b1, 16'sd1000, 1'b1, 15'd100); // stale again
    send_request(OP_SAMPLE,  48'd26_000_000, 1'b1, 16'sd3000, 1'b0, 15'd0); // zero elapsed
    send_request(OP_SET_EXT, 48'd26_100_000, 1'b0, 16'sd1234, 1'b0, 15'd0);
    send_request(OP_QUERY,   48'd31_100_000, 1'b0, 16'sd0,  1'b0, 15'd0);
    send_request(OP_CLR_EXT, 48'd31_200_000, 1'b0, 16'sd0,  1'b0, 15'd0);
    send_request(OP_SAMPLE,  48'hFFFF_FFFF_FFFF, 1'b1, 16'sd32767, 1'b1, 15'd12345);
    send_request(OP_QUERY,   48'd0,          1'b0, 16'sd0,  1'b0, 15'd0);   // back to zero
    settle();

    // Longest time constant, zero window: only same-time values count.
    apply_settings(TAU_MAX, 0);
    send_request(OP_SAMPLE,  48'd5000, 1'b1, 16'sd100, 1'b1, 15'd2560);
    send_request(OP_QUERY,   48'd5000, 1'b0, 16'sd0,   1'b0, 15'd0);
    send_request(OP_QUERY,   48'd5001, 1'b0, 16'sd0,   1'b0, 15'd0);
    send_request(OP_SET_EXT, 48'd5001, 1'b0, 16'sd7777, 1'b0, 15'd0);
    send_request(OP_QUERY,   48'd5001, 1'b0, 16'sd0,   1'b0, 15'd0);
    stamp_now = 48'd5001;

    // Random phases: receiver-heavy stalling, then sender-heavy idling, then none.
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: begin tau = 2000;    validity = 30000; end
        1: begin tau = TAU_MAX; validity = VALIDITY_MAX; end
        2: begin tau = $urandom_range(1, 20000); validity = 1; end
        3: begin tau = 0;       validity = $urandom_range(1, VALIDITY_MAX); end
        4: begin tau = 500;     validity = 2000; end
        default: begin
          tau      = $urandom_range(0, TAU_MAX);
          validity = $urandom_range(1, VALIDITY_MAX);
        end
      endcase
      apply_settings(tau, validity);
      case (phase / 2)
        0: begin sender_gap_pct = 29; receiver_stall_pct = 54; end
        1: begin sender_gap_pct = 54; receiver_stall_pct = 29; end
        default: begin sender_gap_pct = 0; receiver_stall_pct = 0; end
      endcase
      repeat (PHASE_ITEMS) send_random_request();
    end
    settle();

    if (mirror.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
